/* rtl/dtoi_pkg.sv */
// Types and constants shared by the decimal text to integer converter.
`timescale 1ns / 1ps
`default_nettype none

package dtoi_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTRL_LAST = 8'h1F;
    localparam logic [3:0] RADIX    = 4'd10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_SIGNED = 2'd1;

    typedef enum logic [1:0] {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2,
        WSEL_64 = 2'd3
    } t_width_sel;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NAN    = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_EXCEED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        has_char;
        logic        last_char;
        logic [63:0] fallback;
    } t_in_item;

    typedef struct packed {
        logic [63:0] number_bits;
        t_status     status;
    } t_out_item;

    typedef struct packed {
        logic [63:0] magnitude;
        logic        magnitude_overflow;
        logic        fraction_nonzero;
        logic        digits_started;
        logic        minus_seen;
        logic        format_failed;
        logic [63:0] fallback;
    } t_scan_result;

endpackage

`default_nettype wire

/* rtl/dtoi_scan.sv */
// Per-character scanner: parse state, integer accumulator and end-of-text snapshot.
`timescale 1ns / 1ps
`default_nettype none

module dtoi_scan #(
    parameter int ACC_WIDTH = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_item_valid,
    input  dtoi_pkg::t_in_item    i_item,
    output logic                  o_item_ready,
    input  wire                   i_is_signed,
    output logic                  o_fin_valid,
    output dtoi_pkg::t_scan_result o_fin,
    input  wire                   i_fin_ready
);
    import dtoi_pkg::*;

    localparam int PW = ACC_WIDTH + 4;

    logic [ACC_WIDTH-1:0] r_mag, n_mag;
    logic r_ovf, n_ovf;
    logic r_frac, n_frac;
    logic r_sep, n_sep;
    logic r_started, n_started;
    logic r_minus, n_minus;
    logic r_fail, n_fail;
    logic r_fin_valid;
    t_scan_result r_fin, n_fin;

    logic [7:0] w_c;
    logic [7:0] w_diff;
    logic [3:0] w_digit;
    logic [PW-1:0] w_prod;
    logic w_adv;
    logic w_fin_ready;

    assign w_fin_ready  = !r_fin_valid || i_fin_ready;
    assign o_item_ready = !i_item.last_char || w_fin_ready;
    assign w_adv        = i_item_valid && o_item_ready;
    assign w_c          = i_item.char_code;
    assign w_diff       = w_c - CH_ZERO;
    assign w_digit      = w_diff[3:0];
    assign w_prod       = PW'(r_mag) * PW'(RADIX) + PW'(w_digit);

    always_comb begin
        n_mag     = r_mag;
        n_ovf     = r_ovf;
        n_frac    = r_frac;
        n_sep     = r_sep;
        n_started = r_started;
        n_minus   = r_minus;
        n_fail    = r_fail;
        if (i_item.has_char && !r_fail) begin
            if (w_c inside {[8'h00:CH_CTRL_LAST], CH_DEL, CH_SPACE}) begin
                if (r_started) begin
                    n_fail = 1'b1;
                end
            end else if (w_c == CH_MINUS) begin
                if (i_is_signed && !r_started && !r_minus) begin
                    n_minus = 1'b1;
                end else begin
                    n_fail = 1'b1;
                end
            end else if (w_c inside {CH_DOT, CH_COMMA}) begin
                if (!r_sep && r_started) begin
                    n_sep = 1'b1;
                end else begin
                    n_fail = 1'b1;
                end
            end else begin
                n_started = 1'b1;
                if (!(w_c inside {[CH_ZERO:CH_NINE]})) begin
                    n_fail = 1'b1;
                end else if (r_sep) begin
                    if (w_digit != 4'd0) begin
                        n_frac = 1'b1;
                    end
                end else if (!r_ovf) begin
                    if (w_prod[PW-1:ACC_WIDTH] != 4'd0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = w_prod[ACC_WIDTH-1:0];
                    end
                end
            end
        end
        n_fin.magnitude          = 64'(n_mag);
        n_fin.magnitude_overflow = n_ovf;
        n_fin.fraction_nonzero   = n_frac;
        n_fin.digits_started     = n_started;
        n_fin.minus_seen         = n_minus;
        n_fin.format_failed      = n_fail;
        n_fin.fallback           = i_item.fallback;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_ovf       <= 1'b0;
            r_frac      <= 1'b0;
            r_sep       <= 1'b0;
            r_started   <= 1'b0;
            r_minus     <= 1'b0;
            r_fail      <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                if (i_item.last_char) begin
                    r_mag     <= '0;
                    r_ovf     <= 1'b0;
                    r_frac    <= 1'b0;
                    r_sep     <= 1'b0;
                    r_started <= 1'b0;
                    r_minus   <= 1'b0;
                    r_fail    <= 1'b0;
                end else begin
                    r_mag     <= n_mag;
                    r_ovf     <= n_ovf;
                    r_frac    <= n_frac;
                    r_sep     <= n_sep;
                    r_started <= n_started;
                    r_minus   <= n_minus;
                    r_fail    <= n_fail;
                end
            end
            if (w_fin_ready) begin
                r_fin_valid <= w_adv && i_item.last_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_item.last_char) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

`default_nettype wire

/* rtl/dtoi_final.sv */
// End-of-text range check, status selection, sign and width formatting, result register.
`timescale 1ns / 1ps
`default_nettype none

module dtoi_final (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fin_valid,
    input  dtoi_pkg::t_scan_result i_fin,
    output logic                   o_fin_ready,
    input  dtoi_pkg::t_width_sel   i_width_sel,
    input  wire                    i_is_signed,
    output logic                   o_valid,
    output dtoi_pkg::t_out_item    o_item,
    input  wire                    i_stall
);
    import dtoi_pkg::*;

    logic [63:0] w_mask;
    logic [63:0] w_max;
    t_status     w_status;
    t_out_item   n_item;
    t_out_item   r_item;
    logic        r_valid;
    logic        w_load;

    assign o_fin_ready = !r_valid || !i_stall;
    assign w_load      = i_fin_valid && o_fin_ready;

    always_comb begin
        case (i_width_sel)
            WSEL_8:  w_mask = 64'h0000_0000_0000_00FF;
            WSEL_16: w_mask = 64'h0000_0000_0000_FFFF;
            WSEL_32: w_mask = 64'h0000_0000_FFFF_FFFF;
            WSEL_64: w_mask = 64'hFFFF_FFFF_FFFF_FFFF;
            default: w_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        w_max = i_is_signed ? (w_mask >> 1) : w_mask;

        if (i_fin.format_failed) begin
            w_status = ST_NAN;
        end else if (!i_fin.digits_started) begin
            w_status = ST_EMPTY;
        end else if (i_fin.magnitude_overflow || (i_fin.magnitude > w_max)
                     || ((i_fin.magnitude == w_max) && i_fin.fraction_nonzero)) begin
            w_status = ST_EXCEED;
        end else begin
            w_status = ST_OK;
        end

        n_item.status = w_status;
        if (w_status != ST_OK) begin
            n_item.number_bits = i_fin.fallback & w_mask;
        end else if (i_fin.minus_seen) begin
            n_item.number_bits = (64'd0 - i_fin.magnitude) & w_mask;
        end else begin
            n_item.number_bits = i_fin.magnitude & w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/decimal_text_to_integer_top.sv */
// Top level of the decimal text to integer converter.
//
// Input channel: i_valid / o_stall carrying i_item, one text character per item.
// An item is taken at a clock edge with i_valid high and o_stall low. The item
// with last_char set closes the text; items with has_char low carry no character.
// Output channel: o_valid / i_stall carrying o_item, exactly one item per text,
// produced for the closing input item: number_bits at the selected width and a
// status code (ok, not a number, empty, exceeds maximum).
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 selects the target width, index 1 selects signed. Write only while idle.
// A closing item passes through the input register, the scanner snapshot
// register and the output register. Throughput: one item per cycle while o_stall
// is low, set by the single multiply-by-ten-and-add step in the scanner.
// Non-closing items keep flowing while a result is stalled; a closing item waits
// only when both the snapshot and output registers are full. Reset clears all
// parse state and pipeline valids and sets the width to 32 bits, signed.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_integer_top #(
    parameter int ACC_WIDTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  dtoi_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output dtoi_pkg::t_out_item                 o_item,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [dtoi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [dtoi_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dtoi_pkg::*;

    t_width_sel   r_width_sel;
    logic         r_is_signed;
    logic         r_in_valid;
    t_in_item     r_in;
    logic         w_scan_ready;
    logic         w_in_ready;
    logic         w_fin_valid;
    logic         w_fin_ready;
    t_scan_result w_fin;

    assign o_cfg_ready = 1'b1;
    assign w_in_ready  = !r_in_valid || w_scan_ready;
    assign o_stall     = !w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_sel <= WSEL_32;
            r_is_signed <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH_SEL: r_width_sel <= t_width_sel'(i_cfg_data[1:0]);
                CFG_IS_SIGNED: r_is_signed <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_ready) begin
            r_in <= i_item;
        end
    end

    dtoi_scan #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(r_in_valid),
        .i_item      (r_in),
        .o_item_ready(w_scan_ready),
        .i_is_signed (r_is_signed),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_ready (w_fin_ready)
    );

    dtoi_final u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_valid(w_fin_valid),
        .i_fin      (w_fin),
        .o_fin_ready(w_fin_ready),
        .i_width_sel(r_width_sel),
        .i_is_signed(r_is_signed),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );

endmodule

`default_nettype wire
